// ===== rtl/hkb_pkg.sv =====
package hkb_pkg;

  localparam int MaxEntriesDefault = 16;
  localparam logic [4:0] MaxCapReset = 5'd10;
  localparam logic [4:0] CapFieldMax = 5'd31;

  localparam logic CmdUpdate   = 1'b0;
  localparam logic CmdEstimate = 1'b1;

  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegMaxCap    = 2'd1;
  localparam logic [1:0] RegPool      = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word, start match
    logic div_start;  // launch the divider
    logic apply;      // commit the update / estimate
  } hkb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;   // update misses and the bucket is full
    logic div_done;
  } hkb_stat_t;

endpackage

// ===== rtl/hkb_div.sv =====
module hkb_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient,
  output logic        done
);
  import hkb_pkg::*;

  logic [31:0] rem;
  logic [31:0] quo;
  logic [5:0]  step;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, divisor};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        step <= step + 6'd1;
        if (step == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // a zero divisor gives all ones naturally from restoring division
  assign quotient = quo;

endmodule

// ===== rtl/hkb_ctrl.sv =====
module hkb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  input  hkb_pkg::hkb_stat_t stat,
  output hkb_pkg::hkb_cmd_t  cmd
);
  import hkb_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StDiv   = 2'd2;
  localparam logic [1:0] StApply = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // take no word while reset is held
  assign in_ready = (state == StIdle) && !rst;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      StIdle: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = StCheck;
        end
      end
      StCheck: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = StDiv;
        end else begin
          state_next = StApply;
        end
      end
      StDiv: begin
        if (stat.div_done) state_next = StApply;
      end
      StApply: begin
        if (out_free) begin
          cmd.apply  = 1'b1;
          state_next = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= StIdle;
    else     state <= state_next;
  end

endmodule

// ===== rtl/hkb_dp.sv =====
module hkb_dp #(
  parameter int MAX_ENTRIES = hkb_pkg::MaxEntriesDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  hkb_pkg::hkb_cmd_t  cmd,
  output hkb_pkg::hkb_stat_t stat,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_cmd,
  input  logic [31:0]       in_key,
  input  logic [31:0]       in_use,
  output logic [4:0]        res_granted,
  output logic [31:0]       res_estimate
);
  import hkb_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [31:0] threshold;
  logic [4:0]  max_capacity;
  logic [31:0] pool_cells;

  logic [31:0] total_count, error_count;
  logic [4:0]  capacity;
  logic [31:0] entry_key   [MAX_ENTRIES];
  logic [31:0] entry_count [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] entry_valid;

  logic        r_cmd;
  logic [31:0] r_key, r_use;

  logic [MAX_ENTRIES-1:0] hit_vec;
  logic        hit;
  logic [IW-1:0] hit_idx, free_idx;
  logic        has_free;
  logic [CW-1:0] n_valid;

  logic [31:0] quotient;
  logic        div_done;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= 32'd1;
      max_capacity <= MaxCapReset;
      pool_cells   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegThreshold: threshold    <= cfg_data;
        RegMaxCap:    max_capacity <= cfg_data[4:0];
        RegPool:      pool_cells   <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_cmd <= in_cmd;
      r_key <= in_key;
      r_use <= in_use;
    end
  end

  // parallel match, first free slot, occupancy
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    has_free = 1'b0;
    n_valid  = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      hit_vec[i] = entry_valid[i] && (entry_key[i] == r_key);
      if (hit_vec[i]) hit_idx = IW'(i);
      if (!entry_valid[i]) begin
        free_idx = IW'(i);
        has_free = 1'b1;
      end
    end
    for (int i = 0; i < MAX_ENTRIES; i++)
      n_valid = n_valid + CW'(entry_valid[i]);
  end
  assign hit = |hit_vec;

  logic room;
  assign room = ({{(32-CW){1'b0}}, n_valid} < {27'd0, capacity});

  assign stat.need_div = (r_cmd == CmdUpdate) && !hit && !room;
  assign stat.div_done = div_done;

  logic [31:0] total_inc;
  assign total_inc = (total_count == '1) ? total_count : total_count + 32'd1;

  // divide the already incremented total
  hkb_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(total_inc), .divisor(threshold),
    .quotient(quotient), .done(div_done)
  );

  // growth: want = (k+1)(k+2)-1 limited; small k suffices since limit <= 31
  logic [4:0]  lim;
  logic [4:0]  want;
  logic [4:0]  delta;
  logic [31:0] avail;
  logic [4:0]  granted;
  always_comb begin
    lim = max_capacity;
    if (MAX_ENTRIES < 31 && {27'd0, lim} > 32'(MAX_ENTRIES)) lim = 5'(MAX_ENTRIES);
    if (quotient >= 32'd5) want = lim;
    else begin
      case (quotient[2:0])
        3'd0:    want = 5'd1;
        3'd1:    want = 5'd5;
        3'd2:    want = 5'd11;
        3'd3:    want = 5'd19;
        default: want = 5'd29;
      endcase
      if (want > lim) want = lim;
    end
    avail = pool_cells - r_use;
    delta = (want > capacity) ? want - capacity : 5'd0;
    if ({27'd0, delta} > avail) delta = avail[4:0];
    granted = (r_use >= pool_cells) ? 5'd0 : delta;
  end

  logic [32:0] est_sum;
  assign est_sum = {1'b0, error_count} + (hit ? {1'b0, entry_count[hit_idx]} : 33'd0);

  // commit the word's effect on the bucket
  always_ff @(posedge clk) begin
    if (rst) begin
      total_count <= '0;
      error_count <= '0;
      capacity    <= '0;
      entry_valid <= '0;
    end else if (cmd.apply && r_cmd == CmdUpdate) begin
      total_count <= total_inc;
      if (hit) begin
        if (entry_count[hit_idx] != '1)
          entry_count[hit_idx] <= entry_count[hit_idx] + 32'd1;
      end else if (room || granted != 5'd0 || n_valid == '0) begin
        if (!room && granted != 5'd0) capacity <= capacity + granted;
        if (has_free) begin
          entry_valid[free_idx] <= 1'b1;
          entry_key[free_idx]   <= r_key;
          entry_count[free_idx] <= 32'd1;
        end
      end else begin
        if (error_count != '1) error_count <= error_count + 32'd1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (entry_valid[i]) begin
            entry_count[i] <= entry_count[i] - 32'd1;
            if (entry_count[i] == 32'd1) entry_valid[i] <= 1'b0;
          end
        end
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (r_cmd == CmdEstimate) begin
        res_granted  <= '0;
        res_estimate <= est_sum[32] ? 32'hFFFF_FFFF : est_sum[31:0];
      end else begin
        res_granted  <= (!hit && !room) ? granted : 5'd0;
        res_estimate <= '0;
      end
    end
  end

endmodule

// ===== rtl/heavy_key_bucket_update.sv =====
// Heavy-key bucket: one bucket of an expanding heavy-key sketch.
// Input stream s_axis: tdata {cells_in_use, key} (key in the low bits),
// tuser = cmd (0 update, 1 estimate). Output stream m_axis: tdata
// {estimate, cells_granted} with cells_granted in the low bits, padded.
// Every input word yields exactly one output word.
// A hit, an add into spare room or an estimate passes through the check and
// apply states before its output word is registered; an update that must
// try to grow or decrement also runs the 32-step restoring divider between
// the check and apply states.
// One word is worked on at a time; s_axis_tready is high only when the
// block is idle, after the previous result has moved into the output
// register. The output register holds its word while m_axis_tready is
// low; the next word is then taken but its result waits for the slot.
// Configuration: cfg_we/cfg_index/cfg_data, index 0 threshold,
// 1 max_capacity, 2 pool_cells; write only while idle.
// Synchronous reset clears counts, capacity and all entry valid bits and
// restores threshold 1, max_capacity 10, pool_cells 0.
module heavy_key_bucket_update #(
  parameter int MAX_ENTRIES = hkb_pkg::MaxEntriesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key[31:0], cells_in_use[63:32]
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // cells_granted[4:0], estimate[36:5], zero
);
  import hkb_pkg::*;

  hkb_cmd_t  cmd;
  hkb_stat_t stat;
  logic      out_free;
  logic [4:0]  res_granted;
  logic [31:0] res_estimate;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  hkb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_free(out_free), .stat(stat), .cmd(cmd)
  );

  hkb_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_cmd(s_axis_tuser), .in_key(s_axis_tdata[31:0]),
    .in_use(s_axis_tdata[63:32]),
    .res_granted(res_granted), .res_estimate(res_estimate)
  );

  // output valid: set on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.apply) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  assign m_axis_tdata = {3'd0, res_estimate, res_granted};

endmodule

// ===== tb/sv/heavy_key_bucket_update_tb.sv =====
module heavy_key_bucket_update_tb;
  import hkb_pkg::*;

  localparam int NumEntries = 16;
  localparam int DrainCycles = 40;

  typedef struct packed {
    logic        cmd;
    logic [31:0] key;
    logic [31:0] in_use;
  } bucket_req_t;

  typedef struct packed {
    logic [4:0]  granted;
    logic [31:0] est;
  } bucket_resp_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // key[31:0], cells_in_use[63:32]
  logic        s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // cells_granted[4:0], estimate[36:5], zero

  heavy_key_bucket_update u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // bucket shadow state
  logic [31:0] thr_q, pool_q;
  logic [4:0]  maxcap_q;
  logic [31:0] total_q, err_q;
  logic [4:0]  cap_q;
  logic [31:0] ekey [NumEntries];
  logic [31:0] ecnt [NumEntries];
  logic        evalid [NumEntries];

  bucket_req_t  pending_words[$];
  bucket_resp_t expected_results[$];
  bucket_req_t  cur_word;
  logic [31:0]  hot_keys [20];
  int           idle_mode;
  int           mismatch_cnt;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void store_key(logic [31:0] k);
    for (int i = 0; i < NumEntries; i++)
      if (!evalid[i]) begin
        evalid[i] = 1'b1;
        ekey[i] = k;
        ecnt[i] = 32'd1;
        return;
      end
  endfunction

  // cells the bucket may take from the pool on this miss
  function automatic logic [4:0] grow_cells(logic [31:0] in_use);
    logic [31:0] lvl, lim, delta;
    logic [63:0] want;
    if (in_use >= pool_q) return 5'd0;
    lvl = (thr_q == 0) ? 32'hFFFF_FFFF : total_q / thr_q;
    if (lvl > 32'hFFFF) lvl = 32'hFFFF;
    want = (64'(lvl) + 1) * (64'(lvl) + 2) - 1;
    lim = 32'(maxcap_q);
    if (lim > NumEntries) lim = NumEntries;
    if (want > 64'(lim)) want = 64'(lim);
    if (want <= 64'(cap_q)) return 5'd0;
    delta = 32'(want) - 32'(cap_q);
    if (delta > pool_q - in_use) delta = pool_q - in_use;
    return delta[4:0];
  endfunction

  function automatic bucket_resp_t bucket_step(bucket_req_t w);
    bucket_resp_t r;
    int hit, nvalid;
    logic [63:0] s;
    r = '0;
    hit = -1;
    nvalid = 0;
    for (int i = 0; i < NumEntries; i++) begin
      if (evalid[i]) nvalid++;
      if (evalid[i] && ekey[i] == w.key && hit < 0) hit = i;
    end
    if (w.cmd == CmdEstimate) begin
      s = 64'(err_q) + ((hit >= 0) ? 64'(ecnt[hit]) : 64'd0);
      r.est = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    end else begin
      total_q = sat_inc(total_q);
      if (hit >= 0) ecnt[hit] = sat_inc(ecnt[hit]);
      else if (nvalid < cap_q) store_key(w.key);
      else begin
        r.granted = grow_cells(w.in_use);
        if (r.granted != 0) begin
          cap_q = cap_q + r.granted;
          store_key(w.key);
        end else if (nvalid == 0) begin
          // empty bucket: take the key even beyond capacity
          store_key(w.key);
        end else begin
          err_q = sat_inc(err_q);
          for (int i = 0; i < NumEntries; i++)
            if (evalid[i]) begin
              ecnt[i] = ecnt[i] - 1;
              if (ecnt[i] == 0) evalid[i] = 1'b0;
            end
        end
      end
    end
    return r;
  endfunction

  function automatic bool_rand(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver: advance to the next pending word once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) expected_results.push_back(bucket_step(cur_word));
      if (pending_words.size() > 0 && !(idle_mode == 0 && bool_rand(24))
          && !(idle_mode == 1 && bool_rand(59))) begin
        cur_word = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cur_word.in_use, cur_word.key};
        s_axis_tuser  <= cur_word.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: check each result word against the oldest expectation
  always @(posedge clk) begin
    bucket_resp_t exp_r, got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.granted = m_axis_tdata[4:0];
        got.est = m_axis_tdata[36:5];
        if (expected_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result word %h", m_axis_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.granted !== exp_r.granted || got.est !== exp_r.est
              || m_axis_tdata[39:37] !== 3'b0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: granted exp %0d got %0d, estimate exp %h got %h",
                       exp_r.granted, got.granted, exp_r.est, got.est);
          end
        end
      end
      m_axis_tready <= !((idle_mode == 0 && bool_rand(59))
                         || (idle_mode == 1 && bool_rand(24)));
    end
  end

  task automatic wait_idle();
    while (pending_words.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegThreshold: thr_q = val;
      RegMaxCap:    maxcap_q = val[4:0];
      default:      pool_q = val;
    endcase
  endtask

  task automatic set_bucket(logic [31:0] thr, logic [4:0] mc, logic [31:0] pool);
    wait_idle();
    write_reg(RegThreshold, thr);
    write_reg(RegMaxCap, 32'(mc));
    write_reg(RegPool, pool);
  endtask

  task automatic push_word(logic cmd, logic [31:0] key, logic [31:0] in_use);
    bucket_req_t w;
    w.cmd = cmd;
    w.key = key;
    w.in_use = in_use;
    pending_words.push_back(w);
  endtask

  // mostly a small hot key set so hits and decrements happen
  task automatic push_random(int n);
    logic [31:0] k, u;
    for (int i = 0; i < n; i++) begin
      k = bool_rand(85) ? hot_keys[$urandom_range(19, 0)] : $urandom;
      case ($urandom_range(9, 0))
        0:       u = $urandom;
        1:       u = 32'hFFFF_FFFF;
        default: u = $urandom_range(40, 0);
      endcase
      push_word(bool_rand(30) ? CmdEstimate : CmdUpdate, k, u);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    idle_mode = 0;
    mismatch_cnt = 0;
    thr_q = 32'd1;
    maxcap_q = MaxCapReset;
    pool_q = 32'd0;
    total_q = '0;
    err_q = '0;
    cap_q = '0;
    for (int i = 0; i < NumEntries; i++) begin
      evalid[i] = 1'b0;
      ekey[i] = '0;
      ecnt[i] = '0;
    end
    for (int i = 0; i < 20; i++) hot_keys[i] = $urandom;
    hot_keys[0] = 32'h0;
    hot_keys[1] = 32'hFFFF_FFFF;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, empty bucket with no pool, then growth
    push_word(CmdEstimate, 32'h0, 32'h0);
    push_word(CmdUpdate, 32'hFFFF_FFFF, 32'h0);
    push_word(CmdUpdate, 32'h1234_5678, 32'h0);
    push_word(CmdEstimate, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(CmdUpdate, 32'h0, 32'h0);
    set_bucket(32'd1, 5'd16, 32'd100);
    push_word(CmdUpdate, 32'hA5A5_A5A5, 32'd0);
    push_word(CmdUpdate, 32'h5A5A_5A5A, 32'd99);
    push_word(CmdUpdate, 32'h0000_0001, 32'd100);
    push_word(CmdUpdate, 32'h8000_0000, 32'hFFFF_FFFF);
    push_word(CmdUpdate, 32'hA5A5_A5A5, 32'd0);
    push_word(CmdEstimate, 32'hA5A5_A5A5, 32'd0);
    for (int i = 0; i < 8; i++) push_word(CmdUpdate, 32'h100 + i, 32'd3);
    push_word(CmdEstimate, 32'h5A5A_5A5A, 32'd0);
    set_bucket(32'd0, 5'd1, 32'hFFFF_FFFF);
    push_word(CmdUpdate, 32'hDEAD_BEEF, 32'd0);
    push_word(CmdEstimate, 32'hDEAD_BEEF, 32'd0);

    // random phases across settings and idling regimes
    set_bucket(32'd3, 5'd10, 32'd60);
    push_random(200);
    set_bucket($urandom, 5'($urandom_range(16, 1)), $urandom_range(80, 0));
    push_random(150);
    idle_mode = 1;
    set_bucket(32'hFFFF_FFFF, 5'd16, 32'hFFFF_FFFF);
    push_random(200);
    set_bucket(32'd0, 5'd16, 32'd0);
    push_random(150);
    idle_mode = 2;
    set_bucket(32'($urandom_range(8, 1)), 5'd1, 32'd20);
    push_random(200);
    set_bucket(32'd2, 5'($urandom_range(16, 1)), $urandom);
    push_random(200);
    set_bucket($urandom_range(5, 1), 5'd16, 32'd50);
    push_random(230);

    wait_idle();
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hkb_pkg.sv
rtl/hkb_div.sv
rtl/hkb_ctrl.sv
rtl/hkb_dp.sv
rtl/heavy_key_bucket_update.sv
tb/sv/heavy_key_bucket_update_tb.sv
